// ----- src/three_address_instruction_executor_defines.svh -----
// assertion macros shared by the executor modules
// each check is sampled on i_clk and disabled while i_rst_n is low
`ifndef THREE_ADDRESS_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define THREE_ADDRESS_INSTRUCTION_EXECUTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define TAIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("taie: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TAIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("taie: next-cycle check failed");

// condition must never hold
`define TAIE_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("taie: forbidden condition seen");

`else

`define TAIE_ASSERT_IMP(lbl, ante, cons)
`define TAIE_ASSERT_NXT(lbl, ante, cons)
`define TAIE_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ----- src/taie_pkg.sv -----
// ----------------------------------------------------------------------------
// taie_pkg
// Shared constants, command codes and decode for the three-address executor.
// ----------------------------------------------------------------------------
`default_nettype none

package taie_pkg;

    localparam int REG_COUNT_DEF  = 16;
    localparam int MEM_DEPTH_DEF  = 256;
    localparam int PROG_DEPTH_DEF = 65536;

    localparam int CMD_W  = 4;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;
    localparam int SRC_W  = 4;

    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_IMM   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_STORE = 4'd6;
    localparam logic [CMD_W-1:0] CMD_EQ    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LT    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LE    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_GT    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_GE    = 4'd11;
    localparam logic [CMD_W-1:0] CMD_JMP   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_JZ    = 4'd13;
    localparam logic [CMD_W-1:0] CMD_PRINT = 4'd14;
    localparam logic [CMD_W-1:0] CMD_BAD   = 4'd15;

    typedef struct packed {
        logic wr_reg;
        logic div;
        logic load;
        logic store;
        logic print;
        logic jmp;
        logic jz;
        logic bad;
    } t_cls;

    function automatic t_cls classify(input logic [CMD_W-1:0] cmd);
        t_cls c;
        c = '0;
        unique case (cmd)
            CMD_ADD, CMD_MUL, CMD_SUB, CMD_IMM,
            CMD_EQ, CMD_LT, CMD_LE, CMD_GT, CMD_GE: c.wr_reg = 1'b1;
            CMD_DIV: begin
                c.wr_reg = 1'b1;
                c.div    = 1'b1;
            end
            CMD_LOAD: begin
                c.wr_reg = 1'b1;
                c.load   = 1'b1;
            end
            CMD_STORE: c.store = 1'b1;
            CMD_JMP:   c.jmp   = 1'b1;
            CMD_JZ:    c.jz    = 1'b1;
            CMD_PRINT: c.print = 1'b1;
            default:   c.bad   = 1'b1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/three_address_instruction_executor.sv -----
// a popped instruction is latched with its operands read, then executes in S_EX (divide: S_DIV)
// the back end pops a new instruction only after the last one commits; a divide waits in S_DIV
// the divider is iterative (one quotient bit per cycle); commit waits while the output is stalled
// reset: synchronous active-low; afterwards a clearing pass over max(REGISTER_COUNT, MEMORY_DEPTH)
// entries zeroes register file and data memory, with o_in_stall high throughout
// ----------------------------------------------------------------------------
// three_address_instruction_executor
// Top level: front end with decode queue feeding the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module three_address_instruction_executor #(
    parameter int REGISTER_COUNT = taie_pkg::REG_COUNT_DEF,
    parameter int MEMORY_DEPTH   = taie_pkg::MEM_DEPTH_DEF,
    parameter int PROGRAM_DEPTH  = taie_pkg::PROG_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [taie_pkg::CMD_W-1:0]          i_command,
    input  wire logic [taie_pkg::ADDR_W-1:0]         i_field_a,
    input  wire logic signed [taie_pkg::DATA_W-1:0]  i_field_b,
    input  wire logic [taie_pkg::SRC_W-1:0]          i_field_c,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [taie_pkg::ADDR_W-1:0]              o_next_index,
    output logic                                    o_print_valid,
    output logic signed [taie_pkg::DATA_W-1:0]       o_print_value,
    output logic                                    o_bad_command
);
    import taie_pkg::*;

    localparam int RW = $clog2(REGISTER_COUNT);
    localparam int MW = $clog2(MEMORY_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);

    logic              q_valid;
    logic              pop;
    logic              clearing;
    logic [CMD_W-1:0]  q_cmd;
    t_cls              q_cls;
    logic [RW-1:0]     q_rd;
    logic [RW-1:0]     q_rb;
    logic [RW-1:0]     q_rc;
    logic [MW-1:0]     q_mem;
    logic [DATA_W-1:0] q_imm;
    logic [PW-1:0]     q_target;

    taie_fe #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .MEMORY_DEPTH   (MEMORY_DEPTH),
        .PROGRAM_DEPTH  (PROGRAM_DEPTH)
    ) u_fe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_field_a  (i_field_a),
        .i_field_b  (i_field_b),
        .i_field_c  (i_field_c),
        .i_clearing (clearing),
        .i_pop      (pop),
        .o_q_valid  (q_valid),
        .o_cmd      (q_cmd),
        .o_cls      (q_cls),
        .o_rd       (q_rd),
        .o_rb       (q_rb),
        .o_rc       (q_rc),
        .o_mem      (q_mem),
        .o_imm      (q_imm),
        .o_target   (q_target)
    );

    taie_be #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .MEMORY_DEPTH   (MEMORY_DEPTH),
        .PROGRAM_DEPTH  (PROGRAM_DEPTH)
    ) u_be (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .i_cls         (q_cls),
        .i_rd          (q_rd),
        .i_rb          (q_rb),
        .i_rc          (q_rc),
        .i_mem         (q_mem),
        .i_imm         (q_imm),
        .i_target      (q_target),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_next_index  (o_next_index),
        .o_print_valid (o_print_valid),
        .o_print_value (o_print_value),
        .o_bad_command (o_bad_command)
    );

endmodule

`default_nettype wire

// ----- src/taie_div.sv -----
// ----------------------------------------------------------------------------
// taie_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_address_instruction_executor_defines.svh"

module taie_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [taie_pkg::DATA_W-1:0] i_num,
    input  wire logic [taie_pkg::DATA_W-1:0] i_den,
    output logic                            o_done,
    output logic [taie_pkg::DATA_W-1:0]      o_quo
);
    import taie_pkg::*;

    localparam int SW = $clog2(DATA_W);
    localparam logic [SW-1:0] LAST = SW'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_d;
    logic              r_neg;
    logic              r_zero;

    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              fits;

    assign mag_n   = i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
    assign mag_d   = i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
    assign shifted = {r_rem, r_q[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_d};
    assign fits    = !diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_q    <= mag_n;
            r_d    <= mag_d;
            r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_q   <= {r_q[DATA_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '1 : (r_neg ? (DATA_W'(0) - r_q) : r_q);

    `TAIE_ASSERT_NEVER(a_div_restart, i_start && r_busy)
    `TAIE_ASSERT_NXT(a_div_start, i_start, r_busy && !r_done)

endmodule

`default_nettype wire

// ----- src/taie_fe.sv -----
// ----------------------------------------------------------------------------
// taie_fe
// Front end: takes requests, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_address_instruction_executor_defines.svh"

module taie_fe #(
    parameter int REGISTER_COUNT = taie_pkg::REG_COUNT_DEF,
    parameter int MEMORY_DEPTH   = taie_pkg::MEM_DEPTH_DEF,
    parameter int PROGRAM_DEPTH  = taie_pkg::PROG_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [taie_pkg::CMD_W-1:0]          i_command,
    input  wire logic [taie_pkg::ADDR_W-1:0]         i_field_a,
    input  wire logic signed [taie_pkg::DATA_W-1:0]  i_field_b,
    input  wire logic [taie_pkg::SRC_W-1:0]          i_field_c,
    input  wire logic                               i_clearing,
    input  wire logic                               i_pop,
    output logic                                    o_q_valid,
    output logic [taie_pkg::CMD_W-1:0]               o_cmd,
    output taie_pkg::t_cls                          o_cls,
    output logic [$clog2(REGISTER_COUNT)-1:0]        o_rd,
    output logic [$clog2(REGISTER_COUNT)-1:0]        o_rb,
    output logic [$clog2(REGISTER_COUNT)-1:0]        o_rc,
    output logic [$clog2(MEMORY_DEPTH)-1:0]          o_mem,
    output logic [taie_pkg::DATA_W-1:0]              o_imm,
    output logic [$clog2(PROGRAM_DEPTH)-1:0]         o_target
);
    import taie_pkg::*;

    localparam int RW = $clog2(REGISTER_COUNT);
    localparam int MW = $clog2(MEMORY_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int QD = 2;
    localparam logic [1:0] Q_FULL = 2'(QD);

    logic [CMD_W-1:0]  r_q_cmd [QD];
    t_cls              r_q_cls [QD];
    logic [RW-1:0]     r_q_rd  [QD];
    logic [RW-1:0]     r_q_rb  [QD];
    logic [RW-1:0]     r_q_rc  [QD];
    logic [MW-1:0]     r_q_mem [QD];
    logic [DATA_W-1:0] r_q_imm [QD];
    logic [PW-1:0]     r_q_tgt [QD];

    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic push;
    t_cls cls;

    assign o_in_stall = (r_cnt == Q_FULL) || i_clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign cls        = classify(i_command);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wp] <= i_command;
            r_q_cls[r_wp] <= cls;
            r_q_rd[r_wp]  <= RW'(i_field_a);
            r_q_rb[r_wp]  <= RW'($unsigned(i_field_b));
            r_q_rc[r_wp]  <= RW'(i_field_c);
            // load addresses memory by field_b, store and print by field_a
            r_q_mem[r_wp] <= cls.load ? MW'($unsigned(i_field_b)) : MW'(i_field_a);
            r_q_imm[r_wp] <= $unsigned(i_field_b);
            r_q_tgt[r_wp] <= PW'(i_field_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_cmd     = r_q_cmd[r_rp];
    assign o_cls     = r_q_cls[r_rp];
    assign o_rd      = r_q_rd[r_rp];
    assign o_rb      = r_q_rb[r_rp];
    assign o_rc      = r_q_rc[r_rp];
    assign o_mem     = r_q_mem[r_rp];
    assign o_imm     = r_q_imm[r_rp];
    assign o_target  = r_q_tgt[r_rp];

    `TAIE_ASSERT_NEVER(a_pop_empty, i_pop && (r_cnt == '0))

endmodule

`default_nettype wire

// ----- src/taie_be.sv -----
// ----------------------------------------------------------------------------
// taie_be
// Back end: executes queued instructions against register file, data memory
// and program index, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_address_instruction_executor_defines.svh"

module taie_be #(
    parameter int REGISTER_COUNT = taie_pkg::REG_COUNT_DEF,
    parameter int MEMORY_DEPTH   = taie_pkg::MEM_DEPTH_DEF,
    parameter int PROGRAM_DEPTH  = taie_pkg::PROG_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_q_valid,
    input  wire logic [taie_pkg::CMD_W-1:0]          i_cmd,
    input  wire taie_pkg::t_cls                     i_cls,
    input  wire logic [$clog2(REGISTER_COUNT)-1:0]   i_rd,
    input  wire logic [$clog2(REGISTER_COUNT)-1:0]   i_rb,
    input  wire logic [$clog2(REGISTER_COUNT)-1:0]   i_rc,
    input  wire logic [$clog2(MEMORY_DEPTH)-1:0]     i_mem,
    input  wire logic [taie_pkg::DATA_W-1:0]         i_imm,
    input  wire logic [$clog2(PROGRAM_DEPTH)-1:0]    i_target,
    output logic                                    o_pop,
    output logic                                    o_clearing,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [taie_pkg::ADDR_W-1:0]              o_next_index,
    output logic                                    o_print_valid,
    output logic signed [taie_pkg::DATA_W-1:0]       o_print_value,
    output logic                                    o_bad_command
);
    import taie_pkg::*;

    localparam int RW = $clog2(REGISTER_COUNT);
    localparam int MW = $clog2(MEMORY_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int CLR_LEN = (REGISTER_COUNT > MEMORY_DEPTH) ? REGISTER_COUNT : MEMORY_DEPTH;
    localparam int CW = $clog2(CLR_LEN + 1);
    localparam logic [CW-1:0] REG_END  = CW'(REGISTER_COUNT);
    localparam logic [CW-1:0] MEM_END  = CW'(MEMORY_DEPTH);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [DATA_W-1:0] r_rf   [REGISTER_COUNT];
    logic [DATA_W-1:0] r_dmem [MEMORY_DEPTH];

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CW-1:0]     r_clr;
    logic [PW-1:0]     r_pc;

    logic [CMD_W-1:0]  r_cmd;
    t_cls              r_cls;
    logic [RW-1:0]     r_rd;
    logic [MW-1:0]     r_mem;
    logic [DATA_W-1:0] r_imm;
    logic [PW-1:0]     r_target;
    logic [DATA_W-1:0] r_vb;
    logic [DATA_W-1:0] r_vc;
    logic [DATA_W-1:0] r_mdat;

    logic              r_o_valid;
    logic [PW-1:0]     r_o_next;
    logic              r_o_pvalid;
    logic [DATA_W-1:0] r_o_pval;
    logic              r_o_bad;

    logic              clearing;
    logic              out_free;
    logic              commit;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] wr_data;
    logic [PW-1:0]     next_pc;

    logic              rf_we;
    logic [RW-1:0]     rf_wa;
    logic [DATA_W-1:0] rf_wd;
    logic              mem_we;
    logic [MW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;

    assign clearing  = (r_state == S_CLR);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign div_start = (r_state == S_EX) && r_cls.div;
    assign commit    = ((r_state == S_EX) && !r_cls.div && out_free)
                    || ((r_state == S_DIV) && div_done && out_free);

    taie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_vb),
        .i_den   (r_vc),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_comb begin
        alu_res = '0;
        unique case (r_cmd)
            CMD_ADD:  alu_res = r_vb + r_vc;
            CMD_MUL:  alu_res = r_vb * r_vc;
            CMD_SUB:  alu_res = r_vb - r_vc;
            CMD_IMM:  alu_res = r_imm;
            CMD_LOAD: alu_res = r_mdat;
            CMD_EQ:   alu_res = DATA_W'(r_vb == r_vc);
            CMD_LT:   alu_res = DATA_W'($signed(r_vb) <  $signed(r_vc));
            CMD_LE:   alu_res = DATA_W'($signed(r_vb) <= $signed(r_vc));
            CMD_GT:   alu_res = DATA_W'($signed(r_vb) >  $signed(r_vc));
            CMD_GE:   alu_res = DATA_W'($signed(r_vb) >= $signed(r_vc));
            default:  alu_res = '0;
        endcase
    end

    assign wr_data = (r_state == S_DIV) ? div_q : alu_res;
    assign next_pc = (r_cls.jmp || (r_cls.jz && (r_vb == '0))) ? r_target : r_pc + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                if (r_cls.div) begin
                    n_state = S_DIV;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_pc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + 1'b1;
            end
            if (commit) begin
                r_pc      <= next_pc;
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // instruction latched at pop, operands read the same edge
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_cmd;
            r_cls    <= i_cls;
            r_rd     <= i_rd;
            r_mem    <= i_mem;
            r_imm    <= i_imm;
            r_target <= i_target;
        end
        if (commit) begin
            r_o_next   <= next_pc;
            r_o_pvalid <= r_cls.print;
            r_o_pval   <= r_cls.print ? r_mdat : '0;
            r_o_bad    <= r_cls.bad;
        end
    end

    // clearing pass zeroes both stores after reset
    always_comb begin
        rf_we  = 1'b0;
        rf_wa  = r_rd;
        rf_wd  = wr_data;
        mem_we = 1'b0;
        mem_wa = r_mem;
        mem_wd = r_vb;
        if (clearing) begin
            rf_we  = (r_clr < REG_END);
            rf_wa  = r_clr[RW-1:0];
            rf_wd  = '0;
            mem_we = (r_clr < MEM_END);
            mem_wa = r_clr[MW-1:0];
            mem_wd = '0;
        end else if (commit) begin
            rf_we  = r_cls.wr_reg;
            mem_we = r_cls.store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (o_pop) begin
            r_vb <= r_rf[i_rb];
            r_vc <= r_rf[i_rc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dmem[mem_wa] <= mem_wd;
        end
        if (o_pop) begin
            r_mdat <= r_dmem[i_mem];
        end
    end

    assign o_clearing    = clearing;
    assign o_out_valid   = r_o_valid;
    assign o_next_index  = ADDR_W'(r_o_next);
    assign o_print_valid = r_o_pvalid;
    assign o_print_value = $signed(r_o_pval);
    assign o_bad_command = r_o_bad;

    `TAIE_ASSERT_NXT(a_commit_out, commit, r_o_valid)
    `TAIE_ASSERT_NEVER(a_clr_no_out, clearing && r_o_valid)
    `TAIE_ASSERT_IMP(a_div_wait, (r_state == S_DIV) && !div_done, !commit && !o_pop)

endmodule

`default_nettype wire
